/* hdl/mpa_pkg.sv */
// Shared types and constants for the max pooling with argmax unit.
package mpa_pkg;

  localparam int unsigned VAL_W  = 16;  // Q8.8 element
  localparam int unsigned POS_W  = 12;  // row or column position
  localparam int unsigned CHN_W  = 12;  // channel position
  localparam int unsigned SLOT_W = 4;   // line store row slot
  localparam int unsigned DIM_W  = 13;  // clamped sizes and position sums
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 11;

  typedef enum logic [CIDX_W-1:0] {
    CFG_EXTENT   = 3'd0,
    CFG_STRIDE   = 3'd1,
    CFG_HEIGHT   = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_CHANNELS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  extent;
    logic [3:0]  stride;
    logic [8:0]  height;
    logic [8:0]  width;
    logic [10:0] channels;
  } cfg_t;

  // One window candidate handed from front to back.
  typedef struct packed {
    logic [POS_W-1:0]  r0;
    logic [POS_W-1:0]  c0;
    logic [CHN_W-1:0]  ch;
    logic [SLOT_W-1:0] slot;
    logic              done;
  } win_t;

endpackage

/* hdl/mpa_ram.sv */
// Generic single write port, single read port RAM with registered read.
module mpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mpa_queue.sv */
// Two-entry queue of window candidates between front and back.
module mpa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mpa_pkg::win_t    data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output mpa_pkg::win_t    data_o
);

  mpa_pkg::win_t entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= data_i;
  end

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = entry_q[rptr_q];

endmodule

/* hdl/mpa_front.sv */
// Front part: takes elements, writes the line store, flags completed windows.
module mpa_front #(
  parameter int unsigned MAX_EXTENT   = 8,
  parameter int unsigned MAX_WIDTH    = 256,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned MAX_CHANNELS = 1024,
  parameter int unsigned AW           = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [mpa_pkg::VAL_W-1:0]  in_data_i,
  output logic                       in_ready_o,
  input  mpa_pkg::cfg_t              cfg_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output mpa_pkg::win_t              q_entry_o,
  input  logic                       job_done_i,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [mpa_pkg::VAL_W-1:0]  ram_wdata_o,
  output logic [2:0]                 inflight_o
);

  localparam int unsigned DW = mpa_pkg::DIM_W;

  logic [mpa_pkg::POS_W-1:0]  col_q, col_d, row_q, row_d, last_col_q;
  logic [mpa_pkg::CHN_W-1:0]  ch_q, ch_d;
  logic [mpa_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [2:0]                 inflight_q;

  logic [DW-1:0] w, h, c, ext, str, r1, c1, ch1, em1;
  logic          ext_ok, cand, hazard, accept, col_wrap, row_wrap;
  logic [DW-1:0] r_next, ch_next;
  logic          row_step;

  always_comb begin
    w = (cfg_i.width == '0) ? DW'(1) :
        ((DW'(cfg_i.width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(cfg_i.width));
    h = (cfg_i.height == '0) ? DW'(1) :
        ((DW'(cfg_i.height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(cfg_i.height));
    c = (cfg_i.channels == '0) ? DW'(1) :
        ((DW'(cfg_i.channels) > DW'(MAX_CHANNELS)) ? DW'(MAX_CHANNELS)
                                                    : DW'(cfg_i.channels));
    ext = DW'(cfg_i.extent);
    str = DW'(cfg_i.stride);
    r1  = DW'(row_q) + DW'(1);
    c1  = DW'(col_q) + DW'(1);
    ch1 = DW'(ch_q) + DW'(1);
    em1 = ext - DW'(1);
    ext_ok = (ext != '0) && (ext <= DW'(MAX_EXTENT)) && (str != '0);
    cand   = ext_ok && (r1 >= ext) && (c1 >= ext) && (r1 <= h) && (c1 <= w);

    // Hold off while a window is pending and the writer has wrapped back over it.
    hazard   = (inflight_q != 3'd0) && (col_q <= last_col_q);
    accept   = in_valid_i && !q_full_i && !hazard;

    q_entry_o.r0   = mpa_pkg::POS_W'(r1 - ext);
    q_entry_o.c0   = mpa_pkg::POS_W'(c1 - ext);
    q_entry_o.ch   = ch_q;
    q_entry_o.slot = (DW'(slot_q) >= em1) ? mpa_pkg::SLOT_W'(DW'(slot_q) - em1)
                   : mpa_pkg::SLOT_W'(DW'(slot_q) + DW'(MAX_EXTENT) - em1);
    q_entry_o.done = (ch1 == c) && (r1 + str > h) && (c1 + str > w);

    // Advance positions.
    col_wrap = (c1 >= w);
    row_wrap = col_wrap && (r1 >= h);
    row_step = col_wrap && !row_wrap;
    col_d    = col_wrap ? '0 : mpa_pkg::POS_W'(c1);
    r_next   = row_wrap ? '0 : (row_step ? r1 : DW'(row_q));
    ch_next  = row_wrap ? ch1 : DW'(ch_q);
    if (r_next >= h) r_next = '0;
    if (ch_next >= c) ch_next = '0;
    row_d = mpa_pkg::POS_W'(r_next);
    ch_d  = mpa_pkg::CHN_W'(ch_next);
    if (r_next == '0) begin
      slot_d = '0;
    end else if (row_step) begin
      slot_d = (DW'(slot_q) == DW'(MAX_EXTENT - 1)) ? '0 : slot_q + 1'b1;
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      ch_q       <= '0;
      slot_q     <= '0;
      last_col_q <= '0;
      inflight_q <= '0;
    end else begin
      if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        ch_q   <= ch_d;
        slot_q <= slot_d;
        if (cand) last_col_q <= col_q;
      end
      inflight_q <= inflight_q + 3'(accept && cand) - 3'(job_done_i);
    end
  end

  assign in_ready_o  = !q_full_i && !hazard;
  assign q_push_o    = accept && cand;
  assign ram_we_o    = accept;
  assign ram_waddr_o = AW'(32'(slot_q) * MAX_WIDTH + 32'(col_q));
  assign ram_wdata_o = in_data_i;
  assign inflight_o  = inflight_q;

endmodule

/* hdl/mpa_back.sv */
// Back part: checks stride alignment, scans the window, holds the result.
module mpa_back #(
  parameter int unsigned MAX_EXTENT = 8,
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned AW         = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mpa_pkg::cfg_t             cfg_i,
  input  logic                      q_empty_i,
  input  mpa_pkg::win_t             q_entry_i,
  output logic                      q_pop_o,
  output logic [AW-1:0]             ram_raddr_o,
  input  logic [mpa_pkg::VAL_W-1:0] ram_rdata_i,
  output logic                      job_done_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mpa_pkg::VAL_W-1:0] max_o,
  output logic [mpa_pkg::CHN_W-1:0] ch_o,
  output logic [mpa_pkg::POS_W-1:0] orow_o,
  output logic [mpa_pkg::POS_W-1:0] ocol_o,
  output logic [mpa_pkg::POS_W-1:0] arow_o,
  output logic [mpa_pkg::POS_W-1:0] acol_o,
  output logic                      done_o
);

  localparam int unsigned PW = mpa_pkg::POS_W;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SCAN, S_DRAIN, S_OUT} state_e;

  state_e state_q;
  mpa_pkg::win_t job_q;
  logic [PW-1:0] numr_q, numc_q, quor_q, quoc_q;
  logic [4:0]    remr_q, remc_q, remr_s, remc_s, remr_d, remc_d;
  logic [$clog2(PW)-1:0] step_q;
  logic [3:0]    i_q, j_q;
  logic [mpa_pkg::SLOT_W-1:0] slot_q;
  logic          rv_q, first_q;
  logic [PW-1:0] rrow_q, rcol_q;
  logic [mpa_pkg::VAL_W-1:0] best_q;
  logic [PW-1:0] brow_q, bcol_q;
  logic          last_ij, rdiv_bit, cdiv_bit;
  logic [3:0]    em1;

  always_comb begin
    em1     = cfg_i.extent - 4'd1;
    remr_s  = {remr_q[3:0], numr_q[PW-1]};
    remc_s  = {remc_q[3:0], numc_q[PW-1]};
    rdiv_bit = (remr_s >= 5'(cfg_i.stride));
    cdiv_bit = (remc_s >= 5'(cfg_i.stride));
    remr_d  = rdiv_bit ? remr_s - 5'(cfg_i.stride) : remr_s;
    remc_d  = cdiv_bit ? remc_s - 5'(cfg_i.stride) : remc_s;
    last_ij = (i_q == em1) && (j_q == em1);
  end

  assign ram_raddr_o = AW'(32'(slot_q) * MAX_WIDTH + 32'(job_q.c0 + PW'(j_q)));
  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      job_done_o <= 1'b0;
      rv_q       <= 1'b0;
      step_q     <= '0;
    end else begin
      job_done_o <= 1'b0;
      rv_q       <= (state_q == S_SCAN);
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= S_DIV;
            step_q  <= '0;
          end
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (32'(step_q) == PW - 1) begin
            if (remr_d == '0 && remc_d == '0) begin
              state_q <= S_SCAN;
            end else begin
              state_q    <= S_IDLE;
              job_done_o <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (last_ij) state_q <= S_DRAIN;
        end
        S_DRAIN: state_q <= S_OUT;
        S_OUT: begin
          if (out_ready_i) begin
            state_q    <= S_IDLE;
            job_done_o <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: divider shift registers, scan counters, running maximum.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q  <= q_entry_i;
      numr_q <= q_entry_i.r0;
      numc_q <= q_entry_i.c0;
      remr_q <= '0;
      remc_q <= '0;
      quor_q <= '0;
      quoc_q <= '0;
    end
    if (state_q == S_DIV) begin
      numr_q <= numr_q << 1;
      numc_q <= numc_q << 1;
      remr_q <= remr_d;
      remc_q <= remc_d;
      quor_q <= {quor_q[PW-2:0], rdiv_bit};
      quoc_q <= {quoc_q[PW-2:0], cdiv_bit};
      i_q     <= '0;
      j_q     <= '0;
      slot_q  <= job_q.slot;
      first_q <= 1'b1;
    end
    if (state_q == S_SCAN) begin
      rrow_q <= job_q.r0 + PW'(i_q);
      rcol_q <= job_q.c0 + PW'(j_q);
      if (j_q == em1) begin
        j_q    <= '0;
        i_q    <= i_q + 1'b1;
        slot_q <= (32'(slot_q) == MAX_EXTENT - 1) ? '0 : slot_q + 1'b1;
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
    // Replace only on strictly greater: ties keep the first in raster order.
    if (rv_q) begin
      first_q <= 1'b0;
      if (first_q || ($signed(ram_rdata_i) > $signed(best_q))) begin
        best_q <= ram_rdata_i;
        brow_q <= rrow_q;
        bcol_q <= rcol_q;
      end
    end
  end

  assign out_valid_o = (state_q == S_OUT);
  assign max_o  = best_q;
  assign ch_o   = job_q.ch;
  assign orow_o = quor_q;
  assign ocol_o = quoc_q;
  assign arow_o = brow_q;
  assign acol_o = bcol_q;
  assign done_o = job_q.done;

endmodule

/* hdl/max_pool_2d_argmax_unit.sv */
// Streaming 2-D max pooling with argmax over a channels x height x width map.
// Elements enter in raster order, channel slowest, and are written into a line
// store of MAX_EXTENT rows. An element that can close a window is queued to the
// back part. The back part takes the window off the queue and runs a bit-serial
// divider over the 12 position bits that checks stride alignment. A window off
// the stride grid is dropped there. An aligned window is then read out of the
// single-read-port line store, one element per cycle, and after a drain state
// the result is offered on the master side. The input stalls while the queue is
// full, and while a window is pending and the writer wraps to a column at or
// before that window's last column.
module max_pool_2d_argmax_unit #(
  parameter int unsigned MAX_EXTENT   = 8,
  parameter int unsigned MAX_WIDTH    = 256,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned MAX_CHANNELS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mpa_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [mpa_pkg::CDAT_W-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // sample_value
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // max_value, channel_index, out_row, out_col, arg_row, arg_col, zero pad
  output logic [63:0]                  m_axis_tdata,
  output logic                         m_axis_tlast    // sample_done
);

  localparam int unsigned AW = $clog2(MAX_EXTENT * MAX_WIDTH);

  mpa_pkg::cfg_t cfg_q;
  mpa_pkg::win_t push_entry, pop_entry;
  logic push, pop, full, empty, job_done;
  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata, max_v;
  logic [2:0]  inflight;
  logic [mpa_pkg::CHN_W-1:0] ch;
  logic [mpa_pkg::POS_W-1:0] orow, ocol, arow, acol;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extent   <= 4'd2;
      cfg_q.stride   <= 4'd2;
      cfg_q.height   <= 9'd28;
      cfg_q.width    <= 9'd28;
      cfg_q.channels <= 11'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mpa_pkg::CFG_EXTENT:   cfg_q.extent   <= cfg_data_i[3:0];
        mpa_pkg::CFG_STRIDE:   cfg_q.stride   <= cfg_data_i[3:0];
        mpa_pkg::CFG_HEIGHT:   cfg_q.height   <= cfg_data_i[8:0];
        mpa_pkg::CFG_WIDTH:    cfg_q.width    <= cfg_data_i[8:0];
        mpa_pkg::CFG_CHANNELS: cfg_q.channels <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mpa_front #(
    .MAX_EXTENT(MAX_EXTENT), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS), .AW(AW)
  ) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_data_i(s_axis_tdata), .in_ready_o(s_axis_tready),
    .cfg_i(cfg_q), .q_full_i(full), .q_push_o(push), .q_entry_o(push_entry),
    .job_done_i(job_done), .ram_we_o(ram_we), .ram_waddr_o(waddr),
    .ram_wdata_o(wdata), .inflight_o(inflight)
  );

  mpa_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_entry), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(pop_entry)
  );

  mpa_ram #(.WIDTH(16), .DEPTH(MAX_EXTENT * MAX_WIDTH)) u_store (
    .clk_i, .we_i(ram_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  mpa_back #(.MAX_EXTENT(MAX_EXTENT), .MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_empty_i(empty), .q_entry_i(pop_entry),
    .q_pop_o(pop), .ram_raddr_o(raddr), .ram_rdata_i(rdata), .job_done_o(job_done),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .max_o(max_v),
    .ch_o(ch), .orow_o(orow), .ocol_o(ocol), .arow_o(arow), .acol_o(acol),
    .done_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, acol[7:0], arow[7:0], ocol[7:0], orow[7:0],
                         ch[9:0], max_v};

  // A result on the master side always belongs to a window still counted in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight != 3'd0)
    else $error("result without pending window");

  // Windows in flight never exceed queue depth plus the one in the back part.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= 3'd3)
    else $error("window count overflow");

  // The line store is written exactly on an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we == (s_axis_tvalid && s_axis_tready))
    else $error("store write without transfer");

  // A push is never lost to a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("push into full queue");

endmodule
